// ----- rtl/olars_pkg.sv -----
package olars_pkg;

	// List geometry.
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the command and response transactions.
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_REMOVE,
		S_SEARCH,
		S_FINISH
	} state_t;

endpackage

// ----- rtl/olars_cmd_if.sv -----
interface olars_cmd_if;

	logic                                valid;
	logic                                ready;
	logic [olars_pkg::CMD_W-1:0]         command;
	logic signed [olars_pkg::VALUE_W-1:0] value;
	logic [olars_pkg::POS_W-1:0]         position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink (input valid, input command, input value, input position, output ready);

endinterface

// ----- rtl/olars_rsp_if.sv -----
interface olars_rsp_if;

	logic                           valid;
	logic                           ready;
	logic [olars_pkg::STATUS_W-1:0] status;
	logic                           found;
	logic [olars_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output status, output found, output count, input ready);
	modport sink (input valid, input status, input found, input count, output ready);

endinterface

// ----- rtl/ordered_list_append_remove_search.sv -----
// Ordered list of up to CAPACITY signed 32-bit values held in a register file
// with one write and one read port, driven by a small sequencer. Each command
// transaction gives exactly one response transaction carrying a status, a found
// flag and the entry count after the command. The block takes one command at a
// time and drops ready until that command's result has been placed in the
// response register; a finished result may wait there while the next command is
// taken. For every command the block is ready again in the same cycle as its
// result appears. A search reads one stored entry per cycle. A remove moves each
// later entry down one place, one entry per cycle. A result held in the response
// register that has not yet been taken keeps the next result waiting until it is
// taken. These rates follow from the one read and one write that the entry store
// allows per cycle. After reset the list is empty and no clearing pass is needed.
module ordered_list_append_remove_search (
	input logic          clk,
	input logic          arst_n,
	olars_cmd_if.sink    cmd,
	olars_rsp_if.source  rsp
);

	localparam int CAP   = olars_pkg::CAPACITY;
	localparam int AW    = olars_pkg::ADDR_W;
	localparam int CW    = olars_pkg::CNT_W;
	localparam int VW    = olars_pkg::VALUE_W;
	localparam int PW    = olars_pkg::POS_W;
	localparam int CMDW  = olars_pkg::CMD_W;
	localparam int OUTCW = olars_pkg::COUNT_W;

	olars_pkg::state_t  state_q, state_d;
	olars_pkg::status_t status_q, status_d;
	olars_pkg::status_t rsp_status_q;

	logic [CMDW-1:0]  cmd_q;
	logic [VW-1:0]    val_q;
	logic [PW-1:0]    pos_q;
	logic [CW-1:0]    idx_q, idx_d, idx_nxt;
	logic [CW-1:0]    count_q, count_d;
	logic             found_q, found_d;
	logic             rd_vld_s1, rd_vld_d;
	logic [AW-1:0]    wr_addr_s1, wr_addr_d;
	logic [VW-1:0]    rd_data_s1;
	logic             rsp_valid_q, rsp_found_q, rsp_load;
	logic [CW-1:0]    rsp_count_q;
	logic             cmd_acc;

	// Entry store.
	logic [VW-1:0]    mem [CAP];
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VW-1:0]    mem_wdata;

	assign cmd.ready = (state_q == olars_pkg::S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign idx_nxt   = idx_q + CW'(1);

	// The store is written at one address and read at one address per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olars_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store control and working values.
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		found_d   = found_q;
		status_d  = status_q;
		rd_vld_d  = 1'b0;
		wr_addr_d = wr_addr_s1;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = val_q;
		mem_raddr = idx_q[AW-1:0];
		rsp_load  = 1'b0;
		case (state_q)
			olars_pkg::S_IDLE: begin
				if (cmd_acc) begin
					state_d = olars_pkg::S_DECODE;
				end
			end
			olars_pkg::S_DECODE: begin
				found_d  = 1'b0;
				status_d = olars_pkg::ST_DONE;
				state_d  = olars_pkg::S_FINISH;
				case (cmd_q)
					olars_pkg::CMD_APPEND: begin
						if (32'(count_q) >= CAP) begin
							status_d = olars_pkg::ST_FULL;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					olars_pkg::CMD_REMOVE: begin
						if (32'(pos_q) >= 32'(count_q)) begin
							status_d = olars_pkg::ST_RANGE;
						end else begin
							idx_d   = CW'(pos_q);
							state_d = olars_pkg::S_REMOVE;
						end
					end
					olars_pkg::CMD_SEARCH: begin
						idx_d   = '0;
						state_d = olars_pkg::S_SEARCH;
					end
					default: begin
						state_d = olars_pkg::S_FINISH;
					end
				endcase
			end
			olars_pkg::S_REMOVE: begin
				// Read the next entry now and write it one place lower next cycle.
				mem_raddr = idx_nxt[AW-1:0];
				mem_we    = rd_vld_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = rd_data_s1;
				if (idx_nxt < count_q) begin
					rd_vld_d  = 1'b1;
					wr_addr_d = idx_q[AW-1:0];
					idx_d     = idx_nxt;
				end else if (!rd_vld_s1) begin
					count_d = count_q - CW'(1);
					state_d = olars_pkg::S_FINISH;
				end
			end
			olars_pkg::S_SEARCH: begin
				// Scan the stored entries in order, one compare per cycle.
				if (rd_vld_s1 && (rd_data_s1 == val_q)) begin
					found_d = 1'b1;
				end
				if (idx_q < count_q) begin
					rd_vld_d = 1'b1;
					idx_d    = idx_nxt;
				end else if (!rd_vld_s1) begin
					state_d = olars_pkg::S_FINISH;
				end
			end
			olars_pkg::S_FINISH: begin
				rsp_load = !rsp_valid_q || rsp.ready;
				if (rsp_load) begin
					state_d = olars_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = olars_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			idx_q     <= idx_d;
			count_q   <= count_d;
			rd_vld_s1 <= rd_vld_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command capture, working values and the response register.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd.command;
			val_q <= cmd.value;
			pos_q <= cmd.position;
		end
		found_q    <= found_d;
		status_q   <= status_d;
		wr_addr_s1 <= wr_addr_d;
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found  = rsp_found_q;
	assign rsp.count  = OUTCW'(rsp_count_q);

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAP)
		else $error("entry count above capacity");

	// No read is in flight while a new command may be taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !rd_vld_s1)
		else $error("store read pending while ready");

	// A completed remove takes exactly one entry away.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olars_pkg::S_REMOVE && state_d == olars_pkg::S_FINISH)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not decrement the count");

	// The store is written only by an append or during a remove.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == olars_pkg::S_DECODE || state_q == olars_pkg::S_REMOVE))
		else $error("store written outside append or remove");

	// The scan index never runs past the stored entries.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == olars_pkg::S_SEARCH |-> idx_q <= count_q)
		else $error("search index past count");

endmodule
